// File: rtl/core/fud_pkg.sv
package fud_pkg;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChEquals  = 8'h3D;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChTop     = 8'h7F;
  localparam logic [7:0] CaseMask  = 8'hDF;
  localparam logic [7:0] LetterOfs = 8'd10;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    EscIdle  = 2'd0,
    EscFirst = 2'd1,
    EscSecond = 2'd2,
    EscSpare = 2'd3
  } esc_phase_e;

  // One decoded result beat as it travels from the front end to the output stage.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       in_value;
    logic       pair_end;
    logic       bad_escape;
    logic       stream_end;
  } res_t;

  // Queue status seen by the output stage.
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

  // Unchecked hex digit value with 8-bit wrap.
  function automatic logic [7:0] hex_nib(input logic [7:0] c);
    logic [7:0] r;
    if ((c >= ChUpperA) && (c <= ChTop)) begin
      r = (c & CaseMask) - ChUpperA + LetterOfs;
    end else begin
      r = c - ChZero;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/fud_front.sv
module fud_front
  import fud_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       push_o,
  output res_t       res_o
);

  logic       value_side_q, value_side_d;
  esc_phase_e esc_q, esc_d;
  logic [7:0] hi_sum_q, hi_sum_d;
  logic       pair_open_q, pair_open_d;

  logic [7:0] b;
  logic       is_amp;
  logic       is_delim;
  res_t       res;

  always_comb begin
    b        = (in_byte_i == ChPlus) ? ChSpace : in_byte_i;
    is_amp   = (b == ChAmp);
    is_delim = is_amp || ((b == ChEquals) && !value_side_q);

    value_side_d = value_side_q;
    esc_d        = esc_q;
    hi_sum_d     = hi_sum_q;
    pair_open_d  = pair_open_q;
    res          = '0;

    if (is_delim) begin
      if (esc_q != EscIdle) begin
        res.bad_escape = 1'b1;
        esc_d          = EscIdle;
      end
      if (is_amp) begin
        res.pair_end = pair_open_q;
        pair_open_d  = 1'b0;
        value_side_d = 1'b0;
      end else begin
        value_side_d = 1'b1;
        pair_open_d  = 1'b1;
      end
    end else begin
      case (esc_q)
        EscIdle: begin
          pair_open_d = 1'b1;
          if (b == ChPercent) begin
            esc_d = EscFirst;
          end else begin
            res.out_byte   = b;
            res.byte_valid = 1'b1;
            res.in_value   = value_side_q;
          end
        end
        EscFirst: begin
          hi_sum_d = hex_nib(b) << 4;
          esc_d    = EscSecond;
        end
        default: begin
          res.out_byte   = hi_sum_q + hex_nib(b);
          res.byte_valid = 1'b1;
          res.in_value   = value_side_q;
          esc_d          = EscIdle;
        end
      endcase
    end

    // The end of the string closes everything and returns to the reset state.
    if (in_last_i) begin
      if (esc_d != EscIdle) begin
        res.bad_escape = 1'b1;
      end
      if (pair_open_d) begin
        res.pair_end = 1'b1;
      end
      res.stream_end = 1'b1;
      value_side_d   = 1'b0;
      esc_d          = EscIdle;
      hi_sum_d       = '0;
      pair_open_d    = 1'b0;
    end
  end

  assign res_o  = res;
  assign push_o = accept_i &&
                  (res.byte_valid || res.pair_end || res.bad_escape || res.stream_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_side_q <= 1'b0;
      esc_q        <= EscIdle;
      hi_sum_q     <= '0;
      pair_open_q  <= 1'b0;
    end else if (accept_i) begin
      value_side_q <= value_side_d;
      esc_q        <= esc_d;
      hi_sum_q     <= hi_sum_d;
      pair_open_q  <= pair_open_d;
    end
  end

endmodule

// File: rtl/core/fud_queue.sv
module fud_queue
  import fud_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  res_t    push_data_i,
  input  logic    pop_i,
  output res_t    pop_data_o,
  output q_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o       = mem_q[rd_ptr_q];
  assign stat_o.not_empty = (cnt_q != '0);
  assign stat_o.full      = (cnt_q == FullCnt);

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && stat_o.full))
    else $error("queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !stat_o.not_empty))
    else $error("queue read while empty");

  a_count_up : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not follow a write");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue count out of range");

endmodule

// File: rtl/core/fud_back.sv
module fud_back
  import fud_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_stat_t stat_i,
  input  res_t    data_i,
  output logic    pop_o,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output res_t    out_o
);

  logic out_valid_q;
  res_t out_q;

  // Refill the output register from a non-empty queue whenever it is empty or being taken this cycle.
  assign pop_o = stat_i.not_empty && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: rtl/core/form_urlencoded_decoder.sv
// Form-urlencoded stream decoder.
// Input channel: one raw byte per beat on in_byte_i, with in_last_i marking the
// final byte of a string; a beat is taken when in_valid_i is high and in_stall_o
// is low. Output channel: one result beat carrying a decoded byte (tagged name
// or value), a pair end, a dropped-escape flag and/or a stream end. Bytes that
// produce nothing (a '%', the first escape digit, repeated '&') give no beat.
// Throughput is one byte per cycle while in_stall_o is low. A result passes from
// its input beat to the output through the front end, which decodes in the
// accept cycle into a small queue, and the output register, which loads from the queue.
// When the receiver stalls, the output register holds its beat, the queue fills,
// and in_stall_o rises once the queue is full; it depends only on queue state.
// Reset clears the decoder state (name side, no escape, no open pair), empties
// the queue and drops any pending output beat. The decoder also returns to that
// state on its own after every accepted byte marked last.
module form_urlencoded_decoder
  import fud_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       in_value_o,
  output logic       pair_end_o,
  output logic       bad_escape_o,
  output logic       stream_end_o
);

  logic    accept;
  logic    push;
  logic    pop;
  res_t    front_res;
  res_t    q_data;
  res_t    out_res;
  q_stat_t q_stat;

  assign in_stall_o = q_stat.full;
  assign accept     = in_valid_i && !q_stat.full;

  fud_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_byte_i(in_byte_i),
    .in_last_i(in_last_i),
    .push_o   (push),
    .res_o    (front_res)
  );

  fud_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(front_res),
    .pop_i      (pop),
    .pop_data_o (q_data),
    .stat_o     (q_stat)
  );

  fud_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (q_stat),
    .data_i     (q_data),
    .pop_o      (pop),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_o      (out_res)
  );

  assign out_byte_o   = out_res.out_byte;
  assign byte_valid_o = out_res.byte_valid;
  assign in_value_o   = out_res.in_value;
  assign pair_end_o   = out_res.pair_end;
  assign bad_escape_o = out_res.bad_escape;
  assign stream_end_o = out_res.stream_end;

endmodule
